### design/fem_global_matrix_assembly_unit_defines.svh
// Assertion macros shared by the matrix assembly RTL.
`ifndef FEM_GLOBAL_MATRIX_ASSEMBLY_UNIT_DEFINES_SVH
`define FEM_GLOBAL_MATRIX_ASSEMBLY_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define FGMA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FGMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/fgma_pkg.sv
// Types, constants and saturation helpers for the matrix assembly block.
`default_nettype none

package fgma_pkg;

   localparam int NODES_DEF = 64;
   localparam int CMD_W     = 3;
   localparam int NODE_W    = 6;
   localparam int VAL_W     = 32;
   localparam int SUM_W     = 50;

   localparam logic [VAL_W-1:0] INV_DT_RST = 32'd65536;

   localparam logic [CMD_W-1:0] CMD_SET_TEMP  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_ELEM  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_LOAD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_MAT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_LOAD = 3'd4;

   localparam logic signed [SUM_W-1:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_LO = -50'sd2147483648;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [NODE_W-1:0]       row_node;
      logic [NODE_W-1:0]       col_node;
      logic signed [VAL_W-1:0] h_value;
      logic signed [VAL_W-1:0] hbc_value;
      logic signed [VAL_W-1:0] c_value;
      logic signed [VAL_W-1:0] scalar_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] system_entry;
      logic signed [VAL_W-1:0] capacity_entry;
      logic signed [VAL_W-1:0] load_entry;
      logic                    saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_TERM,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic ready;
      logic accept;
      logic clear;
      logic clear_load;
      logic fetch;
      logic scale;
      logic term;
      logic write;
      logic rsp_load;
   } ctrl_type;

   function automatic logic ovf_q(input logic signed [SUM_W-1:0] v);
      return (v > SAT_HI) || (v < SAT_LO);
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/fgma_ctrl.sv
// Sequencer: clearing sweep after reset and per-item step control.
`default_nettype none

module fgma_ctrl import fgma_pkg::*; #(
   parameter int NODES = NODES_DEF,
   localparam int MAT_AW = $clog2(NODES * NODES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [CMD_W-1:0]  item_cmd,
   input  logic              rsp_free,
   output ctrl_type          ctrl,
   output logic [MAT_AW-1:0] clr_addr
);

   state_type         state_ff, state_in;
   logic [MAT_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_last;

   assign clr_last = (clr_cnt_ff == MAT_AW'(NODES * NODES - 1));
   assign clr_addr = clr_cnt_ff;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd inside {CMD_ADD_ELEM, CMD_ADD_LOAD, CMD_READ_MAT,
                                   CMD_READ_LOAD}) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            case (item_cmd)
               CMD_ADD_ELEM: state_in = ST_SCALE;
               CMD_ADD_LOAD: state_in = ST_WRITE;
               default:      state_in = ST_RESP;
            endcase
         end
         ST_SCALE: state_in = ST_TERM;
         ST_TERM:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.ready      = (state_ff == ST_IDLE);
      ctrl.accept     = (state_ff == ST_IDLE) && req_valid;
      ctrl.clear      = (state_ff == ST_CLEAR);
      ctrl.clear_load = (state_ff == ST_CLEAR) && (32'(clr_cnt_ff) < NODES);
      ctrl.fetch      = (state_ff == ST_FETCH);
      ctrl.scale      = (state_ff == ST_SCALE);
      ctrl.term       = (state_ff == ST_TERM);
      ctrl.write      = (state_ff == ST_WRITE);
      ctrl.rsp_load   = (state_ff == ST_RESP) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

endmodule

`default_nettype wire

### design/fgma_mat_store.sv
// System and capacity matrix memories, one read and one write port each.
`default_nettype none

module fgma_mat_store import fgma_pkg::*; #(
   parameter int NODES = NODES_DEF,
   localparam int MAT_AW = $clog2(NODES * NODES)
) (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic [MAT_AW-1:0]       clr_addr,
   input  logic [MAT_AW-1:0]       rd_addr,
   input  logic [MAT_AW-1:0]       wr_addr,
   input  logic                    wr_allow,
   input  logic signed [VAL_W-1:0] sys_wd,
   input  logic signed [VAL_W-1:0] cap_wd,
   output logic signed [VAL_W-1:0] sys_rd,
   output logic signed [VAL_W-1:0] cap_rd
);

   logic signed [VAL_W-1:0] sys_mem [NODES * NODES];
   logic signed [VAL_W-1:0] cap_mem [NODES * NODES];

   logic                    we;
   logic [MAT_AW-1:0]       waddr;
   logic signed [VAL_W-1:0] sys_d, cap_d;

   always_comb begin
      we    = ctrl.clear || (ctrl.write && wr_allow);
      waddr = ctrl.clear ? clr_addr : wr_addr;
      sys_d = ctrl.clear ? '0 : sys_wd;
      cap_d = ctrl.clear ? '0 : cap_wd;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         sys_mem[waddr] <= sys_d;
         cap_mem[waddr] <= cap_d;
      end
      if (ctrl.accept) begin
         sys_rd <= sys_mem[rd_addr];
         cap_rd <= cap_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/fgma_node_store.sv
// Per-node load vector and temperature memories.
`default_nettype none

module fgma_node_store import fgma_pkg::*; #(
   parameter int NODES = NODES_DEF,
   localparam int LD_AW = $clog2(NODES)
) (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic [LD_AW-1:0]        clr_addr,
   input  logic [LD_AW-1:0]        load_rd_addr,
   input  logic [LD_AW-1:0]        temp_rd_addr,
   input  logic                    load_wr_allow,
   input  logic [LD_AW-1:0]        load_wr_addr,
   input  logic signed [VAL_W-1:0] load_wd,
   input  logic                    temp_wr_en,
   input  logic [LD_AW-1:0]        temp_wr_addr,
   input  logic signed [VAL_W-1:0] temp_wd,
   output logic signed [VAL_W-1:0] load_rd,
   output logic signed [VAL_W-1:0] temp_rd
);

   logic signed [VAL_W-1:0] load_mem [NODES];
   logic signed [VAL_W-1:0] temp_mem [NODES];

   logic                    load_we;
   logic [LD_AW-1:0]        load_waddr;
   logic signed [VAL_W-1:0] load_d;

   always_comb begin
      load_we    = ctrl.clear_load || (ctrl.write && load_wr_allow);
      load_waddr = ctrl.clear ? clr_addr : load_wr_addr;
      load_d     = ctrl.clear ? '0 : load_wd;
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         load_mem[load_waddr] <= load_d;
      end
      if (temp_wr_en) begin
         temp_mem[temp_wr_addr] <= temp_wd;
      end
      if (ctrl.accept) begin
         load_rd <= load_mem[load_rd_addr];
         temp_rd <= temp_mem[temp_rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/fgma_arith.sv
// Scaling, load term and saturating accumulation datapath.
`default_nettype none

module fgma_arith import fgma_pkg::*; (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic                    is_elem,
   input  logic                    mat_allow,
   input  logic                    load_allow,
   input  logic signed [VAL_W-1:0] h_value,
   input  logic signed [VAL_W-1:0] hbc_value,
   input  logic signed [VAL_W-1:0] c_value,
   input  logic signed [VAL_W-1:0] scalar_value,
   input  logic [VAL_W-1:0]        inv_time_step,
   input  logic signed [VAL_W-1:0] sys_rd,
   input  logic signed [VAL_W-1:0] cap_rd,
   input  logic signed [VAL_W-1:0] load_rd,
   input  logic signed [VAL_W-1:0] temp_rd,
   output logic signed [VAL_W-1:0] sys_wd,
   output logic signed [VAL_W-1:0] cap_wd,
   output logic signed [VAL_W-1:0] load_wd,
   output logic                    sat_set
);

   logic signed [63:0]      prod1_full;
   logic signed [63:0]      prod1_ff;
   logic signed [63:0]      scaled;
   logic signed [VAL_W-1:0] cdt_ff;
   logic                    cdt_ovf_ff;
   logic signed [63:0]      prod2_full;
   logic signed [63:0]      prod2_ff;
   logic signed [33:0]      hsum_ff;
   logic signed [63:0]      term;
   logic signed [SUM_W-1:0] sys_sum, cap_sum, load_sum, load_add;

   // C * (1/dt), exact.
   assign prod1_full = 64'(c_value) * 64'($signed({1'b0, inv_time_step}));

   // Round half up then drop 16 fraction bits.
   assign scaled = (prod1_ff + 64'sd32768) >>> 16;

   assign prod2_full = 64'(cdt_ff) * 64'(temp_rd);

   assign term = (prod2_ff + 64'sd32768) >>> 16;

   always_comb begin
      load_add = is_elem ? SUM_W'(term) : SUM_W'(scalar_value);
      sys_sum  = SUM_W'(sys_rd) + SUM_W'(hsum_ff);
      cap_sum  = SUM_W'(cap_rd) + SUM_W'(cdt_ff);
      load_sum = SUM_W'(load_rd) + load_add;
      sys_wd   = sat_q(sys_sum);
      cap_wd   = sat_q(cap_sum);
      load_wd  = sat_q(load_sum);
      sat_set  = ctrl.write &&
                 ((mat_allow && (cdt_ovf_ff || ovf_q(sys_sum) || ovf_q(cap_sum))) ||
                  (load_allow && ovf_q(load_sum)));
   end

   always_ff @(posedge clock) begin
      if (ctrl.fetch) begin
         prod1_ff <= prod1_full;
      end
      if (ctrl.scale) begin
         cdt_ff     <= sat_q(SUM_W'(scaled));
         cdt_ovf_ff <= ovf_q(SUM_W'(scaled));
      end
      if (ctrl.term) begin
         prod2_ff <= prod2_full;
         hsum_ff  <= 34'(h_value) + 34'(hbc_value) + 34'(cdt_ff);
      end
   end

endmodule

`default_nettype wire

### design/fem_global_matrix_assembly_unit.sv
// Top level of the transient heat global matrix assembly block.
// Steps: set temperature writes on the transfer; add load entry fetches, then writes;
// add element entry fetches, scales, forms the term, then writes; read commands fetch, then
// load the result once rsp is free. One item at a time: req_ready is low until that item is done.
// Reset: a clearing sweep zeroes the matrices and load vector; req_ready stays low meanwhile.
`default_nettype none
`include "fem_global_matrix_assembly_unit_defines.svh"

module fem_global_matrix_assembly_unit import fgma_pkg::*; #(
   parameter int NODES = NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [VAL_W-1:0]  csr_wr_data
);

   localparam int MAT_AW = $clog2(NODES * NODES);
   localparam int LD_AW  = $clog2(NODES);

   ctrl_type                ctrl;
   logic [MAT_AW-1:0]       clr_addr;

   req_type                 item_ff;
   logic [VAL_W-1:0]        inv_ff;
   logic                    sat_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_next;
   logic                    rsp_free;

   logic                    req_row_ok;
   logic                    row_ok, both_ok;
   logic                    is_elem, is_load, is_rmat, is_rload;
   logic                    mat_allow, load_allow;
   logic [MAT_AW-1:0]       mat_rd_addr, mat_wr_addr;

   logic signed [VAL_W-1:0] sys_rd, cap_rd, load_rd, temp_rd;
   logic signed [VAL_W-1:0] sys_wd, cap_wd, load_wd;
   logic                    sat_set;

   // Range checks: nodes at or past NODES never write a store.
   assign req_row_ok  = 32'(req_data.row_node) < NODES;
   assign row_ok      = 32'(item_ff.row_node) < NODES;
   assign both_ok     = row_ok && (32'(item_ff.col_node) < NODES);

   assign is_elem  = (item_ff.cmd == CMD_ADD_ELEM);
   assign is_load  = (item_ff.cmd == CMD_ADD_LOAD);
   assign is_rmat  = (item_ff.cmd == CMD_READ_MAT);
   assign is_rload = (item_ff.cmd == CMD_READ_LOAD);

   // Element entries touch load[row] only when both nodes are in range.
   assign mat_allow  = is_elem && both_ok;
   assign load_allow = mat_allow || (is_load && row_ok);

   // Row-major matrix addressing; reads take the address straight off the transfer.
   assign mat_rd_addr = MAT_AW'(32'(req_data.row_node) * NODES + 32'(req_data.col_node));
   assign mat_wr_addr = MAT_AW'(32'(item_ff.row_node) * NODES + 32'(item_ff.col_node));

   assign req_ready = ctrl.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fgma_ctrl #(.NODES(NODES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .item_cmd  (item_ff.cmd),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl),
      .clr_addr  (clr_addr)
   );

   fgma_mat_store #(.NODES(NODES)) u_mat_store (
      .clock    (clock),
      .ctrl     (ctrl),
      .clr_addr (clr_addr),
      .rd_addr  (mat_rd_addr),
      .wr_addr  (mat_wr_addr),
      .wr_allow (mat_allow),
      .sys_wd   (sys_wd),
      .cap_wd   (cap_wd),
      .sys_rd   (sys_rd),
      .cap_rd   (cap_rd)
   );

   fgma_node_store #(.NODES(NODES)) u_node_store (
      .clock         (clock),
      .ctrl          (ctrl),
      .clr_addr      (clr_addr[LD_AW-1:0]),
      .load_rd_addr  (LD_AW'(req_data.row_node)),
      .temp_rd_addr  (LD_AW'(req_data.col_node)),
      .load_wr_allow (load_allow),
      .load_wr_addr  (LD_AW'(item_ff.row_node)),
      .load_wd       (load_wd),
      .temp_wr_en    (ctrl.accept && (req_data.cmd == CMD_SET_TEMP) && req_row_ok),
      .temp_wr_addr  (LD_AW'(req_data.row_node)),
      .temp_wd       (req_data.scalar_value),
      .load_rd       (load_rd),
      .temp_rd       (temp_rd)
   );

   fgma_arith u_arith (
      .clock         (clock),
      .ctrl          (ctrl),
      .is_elem       (is_elem),
      .mat_allow     (mat_allow),
      .load_allow    (load_allow),
      .h_value       (item_ff.h_value),
      .hbc_value     (item_ff.hbc_value),
      .c_value       (item_ff.c_value),
      .scalar_value  (item_ff.scalar_value),
      .inv_time_step (inv_ff),
      .sys_rd        (sys_rd),
      .cap_rd        (cap_rd),
      .load_rd       (load_rd),
      .temp_rd       (temp_rd),
      .sys_wd        (sys_wd),
      .cap_wd        (cap_wd),
      .load_wd       (load_wd),
      .sat_set       (sat_set)
   );

   // Build the read result; out-of-range nodes read as zero.
   always_comb begin
      rsp_next                = '0;
      rsp_next.system_entry   = (is_rmat && both_ok) ? sys_rd : '0;
      rsp_next.capacity_entry = (is_rmat && both_ok) ? cap_rd : '0;
      rsp_next.load_entry     = (is_rload && row_ok) ? load_rd : '0;
      rsp_next.saturated      = sat_ff;
   end

   // Hold the item for the whole of its work; payload needs no reset.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         item_ff <= req_data;
      end
      if (ctrl.rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff       <= INV_DT_RST;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            inv_ff <= csr_wr_data;
         end
         // Sticky: set on any saturating scale or accumulation, never drop.
         if (sat_set) begin
            sat_ff <= 1'b1;
         end
         // Advance the output register: load a result or drop a taken one.
         if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `FGMA_ASSERT_SAME(a_no_transfer_in_clear, clock, reset, ctrl.clear, !(req_valid && req_ready), "transfer during clearing sweep")
   `FGMA_ASSERT_NEXT(a_sat_sticky, clock, reset, sat_ff, sat_ff, "saturation flag dropped")
   `FGMA_ASSERT_SAME(a_rsp_from_read, clock, reset, ctrl.rsp_load, is_rmat || is_rload, "result from a non-read command")
   `FGMA_ASSERT_SAME(a_rsp_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !ctrl.rsp_load, "pending result overwritten")

endmodule

`default_nettype wire
